// File: sv/lgr_pkg.sv
// Package with the word types, command codes, address constants and FSM states of the rewriter.
package lgr_pkg;

    localparam int TableDepthDefault = 64;

    localparam logic [31:0] LbV4    = 32'h7F00_0001;
    localparam logic [31:0] GwV4    = 32'h7F00_0002;
    localparam logic [31:0] MapPfx  = 32'h0000_FFFF;
    localparam logic [63:0] GwV6Hi  = 64'hFD77_0000_0000_0000;
    localparam logic [7:0]  ProtoTcp = 8'd6;
    localparam logic [7:0]  ProtoUdp = 8'd17;

    typedef enum logic [2:0] {
        CMD_ADD_GUEST = 3'd0,
        CMD_ADD_HOST  = 3'd1,
        CMD_REM_GUEST = 3'd2,
        CMD_REM_HOST  = 3'd3,
        CMD_OUTBOUND  = 3'd4,
        CMD_INBOUND   = 3'd5,
        CMD_UNUSED6   = 3'd6,
        CMD_UNUSED7   = 3'd7
    } t_cmd;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StNotFound = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic        is_v6;
        logic [7:0]  socket_protocol;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port_number;
    } t_in_word;

    typedef struct packed {
        logic [63:0] out_addr_high;
        logic [63:0] out_addr_low;
        logic        rewritten;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

// File: sv/lgr_ram.sv
// Generic single-port RAM with registered read.
module lgr_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/loopback_gateway_rewriter_core.sv
// Top level of the loopback gateway rewriter: listener tables and sequential search.
// Usage:
//  Input words (t_in_word) arrive on i_in_valid/o_in_stall; result words
//  (t_out_word) leave on o_out_valid/i_out_stall. Every input word gives
//  exactly one result word.
//  Both listener tables share one key RAM of 2*TABLE_DEPTH entries, read
//  one entry a cycle. Every command scans the whole RAM, then decides
//  the result and writes the key on an add in S_WRITE. The result is
//  offered in S_DONE. The block takes one word at a time and stalls its
//  input until the result has been taken.
//  Outbound words test up to three bind keys per table; each RAM entry is
//  compared against all candidate keys at once during the single scan.
//  Reset clears the valid flags of both tables at once; no clearing pass.
//  While the receiver stalls, the result word holds and no input is taken.
module loopback_gateway_rewriter_core
    import lgr_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);
    localparam int Aw = $clog2(TABLE_DEPTH) + 1;
    localparam int Entries = 2 * TABLE_DEPTH;
    localparam logic [Aw:0] LastCnt = (Aw+1)'(Entries);

    t_state r_state, n_state;
    t_in_word r_in;
    logic [Entries-1:0] r_valid, n_valid;
    logic [Aw:0] r_cnt, n_cnt;
    logic [Aw-1:0] r_rd_idx;
    logic r_rd_ok;
    logic r_found, n_found, r_free_ok, n_free_ok;
    logic [Aw-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [5:0] r_hits, n_hits;
    t_out_word r_out, n_out;
    logic r_v6g, r_v6h;
    logic v6c;

    logic [63:0] hi_n, lo_n, khi, klo;
    logic [23:0] pp;
    logic [151:0] rdata, wdata;
    logic ram_we;
    logic [Aw-1:0] ram_addr;
    logic is_table, tsel, okp;
    logic [63:0] m_lb, m_any, m_gw;
    logic [2:0] cand;

    always_comb begin
        hi_n = r_in.is_v6 ? r_in.addr_high : 64'd0;
        lo_n = r_in.is_v6 ? r_in.addr_low : {32'd0, r_in.addr_low[31:0]};
        khi  = hi_n;
        klo  = r_in.is_v6 ? lo_n : {MapPfx, lo_n[31:0]};
        pp   = {r_in.socket_protocol, r_in.port_number};
        is_table = (r_in.command == CMD_ADD_GUEST) || (r_in.command == CMD_ADD_HOST)
                || (r_in.command == CMD_REM_GUEST) || (r_in.command == CMD_REM_HOST);
        tsel = r_in.command[0];
        m_lb  = {MapPfx, LbV4};
        m_any = {MapPfx, 32'd0};
        m_gw  = {MapPfx, GwV4};
        okp = ((r_in.socket_protocol == ProtoTcp) || (r_in.socket_protocol == ProtoUdp))
              && (r_in.port_number != 16'd0);
        wdata = {khi, klo, pp};
    end

    lgr_ram #(.Width(152), .Depth(Entries)) u_keys (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_comb begin
        logic [63:0] e_hi, e_lo;
        logic [23:0] e_pp;
        logic e_tab;
        e_hi = rdata[151:88];
        e_lo = rdata[87:24];
        e_pp = rdata[23:0];
        e_tab = r_rd_idx[Aw-1];
        n_state = r_state;
        n_valid = r_valid;
        n_cnt = r_cnt;
        n_found = r_found;
        n_free_ok = r_free_ok;
        n_hit_idx = r_hit_idx;
        n_free_idx = r_free_idx;
        n_hits = r_hits;
        n_out = r_out;
        ram_we = 1'b0;
        ram_addr = r_cnt[Aw-1:0];
        cand[0] = (e_hi == 64'd0) && (e_lo == m_lb) && (e_pp == pp);
        cand[1] = (e_hi == 64'd0) && (e_lo == m_any) && (e_pp == pp);
        cand[2] = (e_hi == 64'd0) && (e_lo == 64'd0) && (e_pp == pp);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                    n_cnt = '0;
                    n_found = 1'b0;
                    n_free_ok = 1'b0;
                    n_hits = '0;
                end
            end
            S_SCAN: begin
                if (r_rd_ok && r_valid[r_rd_idx]) begin
                    if (is_table && e_tab == tsel && !r_found && e_hi == khi
                        && e_lo == klo && e_pp == pp) begin
                        n_found = 1'b1;
                        n_hit_idx = r_rd_idx;
                    end
                    if (e_tab) begin
                        n_hits[5:3] = r_hits[5:3] | cand;
                    end else begin
                        n_hits[2:0] = r_hits[2:0] | cand;
                    end
                end
                if (r_rd_ok && !r_valid[r_rd_idx] && is_table && e_tab == tsel
                    && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free_idx = r_rd_idx;
                end
                if (r_cnt == LastCnt) begin
                    n_state = S_WRITE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WRITE: begin
                n_out = '0;
                n_state = S_DONE;
                unique case (r_in.command)
                    CMD_ADD_GUEST, CMD_ADD_HOST: begin
                        if (!r_found) begin
                            if (r_free_ok) begin
                                ram_we = 1'b1;
                                ram_addr = r_free_idx;
                                n_valid[r_free_idx] = 1'b1;
                            end else begin
                                n_out.status = StFull;
                            end
                        end
                    end
                    CMD_REM_GUEST, CMD_REM_HOST: begin
                        if (r_found) n_valid[r_hit_idx] = 1'b0;
                        else n_out.status = StNotFound;
                    end
                    CMD_OUTBOUND: begin
                        n_out.out_addr_high = hi_n;
                        n_out.out_addr_low = lo_n;
                        if (!r_in.is_v6) begin
                            if (okp && lo_n == {32'd0, LbV4} && !(|r_hits[2:0])
                                && (|r_hits[5:3])) begin
                                n_out.out_addr_low = {32'd0, GwV4};
                                n_out.rewritten = 1'b1;
                            end
                        end else if (okp && hi_n == 64'd0) begin
                            if (lo_n == m_lb) begin
                                if (!(|r_hits[2:0]) && (|r_hits[5:3])) begin
                                    n_out.out_addr_low = m_gw;
                                    n_out.rewritten = 1'b1;
                                end
                            end else if (lo_n == 64'd1) begin
                                if (!r_v6g && r_v6h) begin
                                    n_out.out_addr_high = GwV6Hi;
                                    n_out.out_addr_low = 64'd2;
                                    n_out.rewritten = 1'b1;
                                end
                            end
                        end
                    end
                    CMD_INBOUND: begin
                        n_out.out_addr_high = hi_n;
                        n_out.out_addr_low = lo_n;
                        if (!r_in.is_v6) begin
                            if (lo_n == {32'd0, GwV4}) begin
                                n_out.out_addr_low = {32'd0, LbV4};
                                n_out.rewritten = 1'b1;
                            end
                        end else if (hi_n == GwV6Hi && lo_n == 64'd2) begin
                            n_out.out_addr_high = 64'd0;
                            n_out.out_addr_low = 64'd1;
                            n_out.rewritten = 1'b1;
                        end else if (hi_n == 64'd0 && lo_n == m_gw) begin
                            n_out.out_addr_low = m_lb;
                            n_out.rewritten = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // IPv6 loopback service: a bind to ::1 or to :: for the same protocol and port.
    assign v6c = (rdata[151:88] == 64'd0) && (rdata[23:0] == pp)
               && ((rdata[87:24] == 64'd1) || (rdata[87:24] == 64'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_rd_ok <= (r_state == S_SCAN) && (r_cnt < LastCnt);
        end
        if (r_state == S_IDLE) begin
            r_in <= i_in_data;
            r_v6g <= 1'b0;
            r_v6h <= 1'b0;
        end else if (r_state == S_SCAN && r_rd_ok && r_valid[r_rd_idx] && v6c) begin
            if (r_rd_idx[Aw-1]) r_v6h <= 1'b1;
            else r_v6g <= 1'b1;
        end
        r_rd_idx <= r_cnt[Aw-1:0];
        r_cnt <= n_cnt;
        r_found <= n_found;
        r_free_ok <= n_free_ok;
        r_hit_idx <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hits <= n_hits;
        r_out <= n_out;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data = r_out;
endmodule

// File: bench/loopback_gateway_rewriter_core_tb.sv
// Testbench for the loopback gateway rewriter: random and directed words checked against a model.
module loopback_gateway_rewriter_core_tb;
    import lgr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class rewrite_scoreboard;
        bit        guest_v[64];
        logic [63:0] guest_hi[64], guest_lo[64];
        logic [23:0] guest_pp[64];
        bit        host_v[64];
        logic [63:0] host_hi[64], host_lo[64];
        logic [23:0] host_pp[64];
        t_out_word pending[$];
        int        mismatches;

        function int find_key(bit is_host, logic [63:0] hi, logic [63:0] lo, logic [23:0] pp);
            for (int i = 0; i < 64; i++) begin
                if (is_host) begin
                    if (host_v[i] && host_hi[i] == hi && host_lo[i] == lo && host_pp[i] == pp)
                        return i;
                end else begin
                    if (guest_v[i] && guest_hi[i] == hi && guest_lo[i] == lo
                        && guest_pp[i] == pp)
                        return i;
                end
            end
            return -1;
        endfunction

        function bit served_ipv4(bit is_host, logic [23:0] pp);
            return find_key(is_host, 64'd0, {MapPfx, LbV4}, pp) >= 0 ||
                   find_key(is_host, 64'd0, {MapPfx, 32'h0}, pp) >= 0 ||
                   find_key(is_host, 64'd0, 64'd0, pp) >= 0;
        endfunction

        function bit served_ipv6(bit is_host, logic [23:0] pp);
            return find_key(is_host, 64'd0, 64'd1, pp) >= 0 ||
                   find_key(is_host, 64'd0, 64'd0, pp) >= 0;
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            logic [63:0] hi, lo, khi, klo;
            logic [23:0] pp;
            bit is_host, okp;
            int idx;
            r = '0;
            hi = w.addr_high;
            lo = w.addr_low;
            pp = {w.socket_protocol, w.port_number};
            if (!w.is_v6) begin
                hi = 64'd0;
                lo = {32'h0, lo[31:0]};
            end
            if (w.command inside {CMD_ADD_GUEST, CMD_ADD_HOST, CMD_REM_GUEST, CMD_REM_HOST}) begin
                khi = hi;
                klo = w.is_v6 ? lo : {MapPfx, lo[31:0]};
                is_host = w.command[0];
                idx = find_key(is_host, khi, klo, pp);
                if (w.command == CMD_ADD_GUEST || w.command == CMD_ADD_HOST) begin
                    if (idx < 0) begin
                        r.status = StFull;
                        for (int i = 0; i < 64; i++) begin
                            if (r.status == StFull && !(is_host ? host_v[i] : guest_v[i])) begin
                                r.status = StOk;
                                if (is_host) begin
                                    host_v[i] = 1'b1; host_hi[i] = khi;
                                    host_lo[i] = klo; host_pp[i] = pp;
                                end else begin
                                    guest_v[i] = 1'b1; guest_hi[i] = khi;
                                    guest_lo[i] = klo; guest_pp[i] = pp;
                                end
                            end
                        end
                    end
                end else if (idx < 0) begin
                    r.status = StNotFound;
                end else if (is_host) begin
                    host_v[idx] = 1'b0;
                end else begin
                    guest_v[idx] = 1'b0;
                end
            end else if (w.command == CMD_OUTBOUND) begin
                okp = (w.socket_protocol == ProtoTcp || w.socket_protocol == ProtoUdp)
                      && w.port_number != 16'd0;
                r.out_addr_high = hi;
                r.out_addr_low = lo;
                if (!w.is_v6) begin
                    if (okp && lo == {32'h0, LbV4} && !served_ipv4(1'b0, pp)
                        && served_ipv4(1'b1, pp)) begin
                        r.out_addr_low = {32'h0, GwV4};
                        r.rewritten = 1'b1;
                    end
                end else if (okp && hi == 64'd0) begin
                    if (lo == {MapPfx, LbV4}) begin
                        if (!served_ipv4(1'b0, pp) && served_ipv4(1'b1, pp)) begin
                            r.out_addr_low = {MapPfx, GwV4};
                            r.rewritten = 1'b1;
                        end
                    end else if (lo == 64'd1) begin
                        if (!served_ipv6(1'b0, pp) && served_ipv6(1'b1, pp)) begin
                            r.out_addr_high = GwV6Hi;
                            r.out_addr_low = 64'd2;
                            r.rewritten = 1'b1;
                        end
                    end
                end
            end else if (w.command == CMD_INBOUND) begin
                r.out_addr_high = hi;
                r.out_addr_low = lo;
                if (!w.is_v6) begin
                    if (lo == {32'h0, GwV4}) begin
                        r.out_addr_low = {32'h0, LbV4};
                        r.rewritten = 1'b1;
                    end
                end else if (hi == GwV6Hi && lo == 64'd2) begin
                    r.out_addr_high = 64'd0;
                    r.out_addr_low = 64'd1;
                    r.rewritten = 1'b1;
                end else if (hi == 64'd0 && lo == {MapPfx, GwV4}) begin
                    r.out_addr_low = {MapPfx, LbV4};
                    r.rewritten = 1'b1;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.out_addr_high !== exp_w.out_addr_high || got.out_addr_low !== exp_w.out_addr_low
                || got.rewritten !== exp_w.rewritten || got.status !== exp_w.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected hi %h lo %h rw %b st %0d, ",
                              "got hi %h lo %h rw %b st %0d"},
                             exp_w.out_addr_high, exp_w.out_addr_low, exp_w.rewritten,
                             exp_w.status, got.out_addr_high, got.out_addr_low,
                             got.rewritten, got.status);
            end
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_word o_out_data;

    rewrite_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    bit hold_done = 0;

    loopback_gateway_rewriter_core DUT (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cycles <= 600;
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(t_cmd c, bit v6, logic [7:0] pr, logic [63:0] hi,
                                           logic [63:0] lo, logic [15:0] pt);
        t_in_word w;
        w.command = c; w.is_v6 = v6; w.socket_protocol = pr;
        w.addr_high = hi; w.addr_low = lo; w.port_number = pt;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        logic [191:0] rnd;
        logic [15:0] ports[4] = '{16'd80, 16'd443, 16'd1, 16'hFFFF};
        int k;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = rnd[$bits(t_in_word)-1:0];
        if ($urandom_range(9) < 8) begin
            w.command = t_cmd'($urandom_range(5));
            w.socket_protocol = $urandom_range(1) ? ProtoTcp : ProtoUdp;
            w.port_number = ports[$urandom_range(3)];
            k = $urandom_range(7);
            w.addr_high = '0;
            case (k)
                0: w.addr_low = {$urandom, LbV4};
                1: w.addr_low = {$urandom, 32'h0};
                2: begin w.is_v6 = 1'b1; w.addr_low = 64'd0; end
                3: begin w.is_v6 = 1'b1; w.addr_low = 64'd1; end
                4: begin w.is_v6 = 1'b1; w.addr_low = {MapPfx, LbV4}; end
                5: w.addr_low = {$urandom, GwV4};
                6: begin w.is_v6 = 1'b1; w.addr_high = GwV6Hi; w.addr_low = 64'd2; end
                default: begin w.is_v6 = 1'b1; w.addr_low = {MapPfx, GwV4}; end
            endcase
            if ($urandom_range(15) == 0) w.port_number = 16'd0;
        end
        return w;
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_word(make_word(CMD_OUTBOUND, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd80));
        send_word(make_word(CMD_ADD_HOST, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd80));
        send_word(make_word(CMD_ADD_HOST, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd80));
        send_word(make_word(CMD_OUTBOUND, 1'b0, ProtoTcp, 64'hFFFF_FFFF_FFFF_FFFF,
                            {32'hFFFF_FFFF, LbV4}, 16'd80));
        send_word(make_word(CMD_OUTBOUND, 1'b1, ProtoTcp, 64'd0, {MapPfx, LbV4}, 16'd80));
        send_word(make_word(CMD_OUTBOUND, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd0));
        send_word(make_word(CMD_OUTBOUND, 1'b0, 8'hFF, 64'd0, {32'd0, LbV4}, 16'd80));
        send_word(make_word(CMD_ADD_GUEST, 1'b1, ProtoTcp, 64'd0, 64'd0, 16'd80));
        send_word(make_word(CMD_OUTBOUND, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd80));
        send_word(make_word(CMD_REM_GUEST, 1'b1, ProtoTcp, 64'd0, 64'd0, 16'd80));
        send_word(make_word(CMD_REM_GUEST, 1'b1, ProtoTcp, 64'd0, 64'd0, 16'd80));
        send_word(make_word(CMD_ADD_HOST, 1'b1, ProtoUdp, 64'd0, 64'd1, 16'hFFFF));
        send_word(make_word(CMD_OUTBOUND, 1'b1, ProtoUdp, 64'd0, 64'd1, 16'hFFFF));
        send_word(make_word(CMD_INBOUND, 1'b1, 8'd0, GwV6Hi, 64'd2, 16'd0));
        send_word(make_word(CMD_INBOUND, 1'b1, 8'd0, 64'd0, {MapPfx, GwV4}, 16'd0));
        send_word(make_word(CMD_INBOUND, 1'b0, 8'd0, 64'd0, {32'd0, GwV4}, 16'd0));
        send_word(make_word(CMD_UNUSED6, 1'b1, 8'hFF, '1, '1, 16'hFFFF));
        send_word(make_word(CMD_UNUSED7, 1'b0, 8'd0, 64'd0, 64'd0, 16'd0));
        send_word(make_word(CMD_REM_HOST, 1'b0, ProtoTcp, 64'd0, {32'd0, LbV4}, 16'd80));
        for (int i = 0; i < 66; i++)
            send_word(make_word(CMD_ADD_GUEST, 1'b1, 8'd1, 64'd0, 64'(i), 16'd7));
        for (int i = 0; i < 66; i++)
            send_word(make_word(CMD_REM_GUEST, 1'b1, 8'd1, 64'd0, 64'(i), 16'd7));
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 7) : 0;
            recv_stall_pct = (ph == 2) ? 54 : ((ph == 3) ? 7 : 0);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 370; n++) send_word(random_word());
            drain();
        end
        repeat (300) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/lgr_pkg.sv
sv/lgr_ram.sv
sv/loopback_gateway_rewriter_core.sv
bench/loopback_gateway_rewriter_core_tb.sv
